[design/bracket_stack_balance_checker_top_macros.svh]
// Assertion macros used by the bracket stack checker RTL.
// Depends on clk and rst being visible in the module that uses them.
`ifndef BRACKET_STACK_BALANCE_CHECKER_TOP_MACROS_SVH
`define BRACKET_STACK_BALANCE_CHECKER_TOP_MACROS_SVH

// same-cycle implication
`define BSBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bsbc_pkg.sv]
// Shared types, constants and bracket decode functions for the bracket stack checker.
// No dependencies.
package bsbc_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;

  localparam logic KIND_TOP = 1'b0;
  localparam logic KIND_BAL = 1'b1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_TOP   = 2'd2,
    OP_QUERY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    BR_NONE   = 2'd0,
    BR_PAREN  = 2'd1,
    BR_SQUARE = 2'd2,
    BR_CURLY  = 2'd3
  } br_code_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_TOP_WAIT,
    B_SCAN_RD,
    B_SCAN_EV
  } back_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_in;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] top_char;
    logic       balanced;
  } rsp_t;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] ch;
  } cmd_t;

  function automatic br_code_t opener_code(input logic [7:0] c);
    br_code_t r;
    r = BR_NONE;
    if (c == CH_LPAREN)  r = BR_PAREN;
    if (c == CH_LSQUARE) r = BR_SQUARE;
    if (c == CH_LCURLY)  r = BR_CURLY;
    return r;
  endfunction

  function automatic br_code_t closer_code(input logic [7:0] c);
    br_code_t r;
    r = BR_NONE;
    if (c == CH_RPAREN)  r = BR_PAREN;
    if (c == CH_RSQUARE) r = BR_SQUARE;
    if (c == CH_RCURLY)  r = BR_CURLY;
    return r;
  endfunction

endpackage

[design/bracket_stack_balance_checker_top.sv]
// Bracket stack checker top level: front end, command queue and stack engine.
// Depends on bsbc_pkg, bsbc_front, bsbc_queue and bsbc_back.
//
// Push appends a byte (dropped when the 1024-entry stack is full), pop removes the top,
// read top answers with the top byte (no answer on an empty stack), and query answers
// whether the stored bytes form a balanced (), [], {} sequence. The front end takes a
// request beat every cycle while its 4-entry command queue has room. The stack engine
// takes push and pop in its idle state, reads the top byte for read top and registers it
// from a top-wait state, answers a query whose cached answer is still current from the
// cache, and after a push or pop accepts the query and rescans the stored bytes: for each
// byte it reads the byte from the byte memory and then evaluates it against the opener
// work stack, and it closes the scan once every byte is read. No command is taken mid-scan.
// A closer mismatch ends the rescan early. Read top and query wait for the result
// register to empty. No clearing pass follows reset.
module bracket_stack_balance_checker_top import bsbc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  bsbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  bsbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  bsbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[design/bsbc_front.sv]
// Front end: accepts request beats, decodes the opcode and hands commands to the queue.
// Depends on bsbc_pkg.
module bsbc_front import bsbc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  logic stage_valid;
  cmd_t stage_cmd;

  assign req_ready = !stage_valid || cmd_ready;
  assign cmd_valid = stage_valid;
  assign cmd       = stage_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      stage_valid <= 1'b1;
    end else if (cmd_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage_cmd.op <= opcode_t'(req.opcode);
      // only a push carries a byte
      stage_cmd.ch <= (opcode_t'(req.opcode) == OP_PUSH) ? req.char_in : 8'h00;
    end
  end

endmodule

[design/bsbc_queue.sv]
// Small command FIFO between the front end and the stack engine.
// Depends on bsbc_pkg.
module bsbc_queue import bsbc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule

[design/bsbc_back.sv]
// Stack engine: byte store, fill count, cached balance answer, rescan sequencer, result register.
// Depends on bsbc_pkg and the assertion macro header.
`include "bracket_stack_balance_checker_top_macros.svh"

module bsbc_back import bsbc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  back_state_t state, state_next;

  logic [CNT_W-1:0] fill_count;
  logic             stale;
  logic             cached;
  logic             res_valid;
  rsp_t             res;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] scan_depth;

  logic [7:0]        char_store [STACK_DEPTH];
  logic [1:0]        scratch    [STACK_DEPTH];
  logic [7:0]        char_rdata;
  logic [1:0]        scr_rdata;
  logic              char_we, char_re, scr_we, scr_re;
  logic [ADDR_W-1:0] char_raddr;

  logic             full, empty, take, scan_end, ev_fail;
  logic [CNT_W-1:0] fill_m1, depth_m1;
  br_code_t         ev_op, ev_cl;

  assign full     = fill_count == CNT_W'(STACK_DEPTH);
  assign empty    = fill_count == '0;
  assign fill_m1  = fill_count - 1'b1;
  assign depth_m1 = scan_depth - 1'b1;
  assign take     = q_valid && q_ready;
  assign scan_end = scan_idx == fill_count;
  assign ev_op    = opener_code(char_rdata);
  assign ev_cl    = closer_code(char_rdata);
  // closer with nothing open, or against a different opener
  assign ev_fail  = (ev_cl != BR_NONE) &&
                    ((scan_depth == '0) || (scr_rdata != 2'(ev_cl)));

  assign rsp_valid = res_valid;
  assign rsp       = res;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (take && q_cmd.op == OP_TOP && !empty) state_next = B_TOP_WAIT;
        if (take && q_cmd.op == OP_QUERY && stale) state_next = B_SCAN_RD;
      end
      B_TOP_WAIT: state_next = B_IDLE;
      B_SCAN_RD:  state_next = scan_end ? B_IDLE : B_SCAN_EV;
      B_SCAN_EV:  state_next = ev_fail ? B_IDLE : B_SCAN_RD;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_ready    = 1'b0;
    char_we    = 1'b0;
    char_re    = 1'b0;
    char_raddr = scan_idx[ADDR_W-1:0];
    scr_we     = 1'b0;
    scr_re     = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            OP_PUSH: begin
              q_ready = 1'b1;
              char_we = !full;
            end
            OP_POP: q_ready = 1'b1;
            OP_TOP: begin
              if (empty) begin
                q_ready = 1'b1;
              end else if (!res_valid) begin
                q_ready    = 1'b1;
                char_re    = 1'b1;
                char_raddr = fill_m1[ADDR_W-1:0];
              end
            end
            OP_QUERY: q_ready = !res_valid;
            default:  q_ready = 1'b0;
          endcase
        end
      end
      B_SCAN_RD: begin
        char_re = !scan_end;
        scr_re  = !scan_end && (scan_depth != '0);
      end
      B_SCAN_EV: begin
        scr_we = (ev_op != BR_NONE) && (scan_depth < CNT_W'(STACK_DEPTH));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (char_we) char_store[fill_count[ADDR_W-1:0]] <= q_cmd.ch;
    if (char_re) char_rdata <= char_store[char_raddr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) scratch[scan_depth[ADDR_W-1:0]] <= 2'(ev_op);
    if (scr_re) scr_rdata <= scratch[depth_m1[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      fill_count <= '0;
      stale      <= 1'b1;
      cached     <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && rsp_ready) res_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (take) begin
            unique case (q_cmd.op)
              OP_PUSH: begin
                if (!full) begin
                  fill_count <= fill_count + 1'b1;
                  stale      <= 1'b1;
                end
              end
              OP_POP: begin
                if (!empty) begin
                  fill_count <= fill_m1;
                  stale      <= 1'b1;
                end
              end
              OP_QUERY: begin
                if (!stale) res_valid <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        B_TOP_WAIT: res_valid <= 1'b1;
        B_SCAN_RD: begin
          if (scan_end) begin
            cached    <= scan_depth == '0;
            stale     <= 1'b0;
            res_valid <= 1'b1;
          end
        end
        B_SCAN_EV: begin
          if (ev_fail) begin
            cached    <= 1'b0;
            stale     <= 1'b0;
            res_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result payload and scan counters
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (take && q_cmd.op == OP_QUERY) begin
          scan_idx   <= '0;
          scan_depth <= '0;
          res        <= '{kind: KIND_BAL, top_char: 8'h00, balanced: cached};
        end
      end
      B_TOP_WAIT: res <= '{kind: KIND_TOP, top_char: char_rdata, balanced: 1'b0};
      B_SCAN_RD: begin
        if (scan_end) begin
          res <= '{kind: KIND_BAL, top_char: 8'h00, balanced: (scan_depth == '0)};
        end
      end
      B_SCAN_EV: begin
        if (ev_fail) begin
          res <= '{kind: KIND_BAL, top_char: 8'h00, balanced: 1'b0};
        end else begin
          scan_idx <= scan_idx + 1'b1;
          if (ev_op != BR_NONE && scan_depth < CNT_W'(STACK_DEPTH)) begin
            scan_depth <= scan_depth + 1'b1;
          end else if (ev_cl != BR_NONE) begin
            scan_depth <= depth_m1;
          end
        end
      end
      default: ;
    endcase
  end

  `BSBC_ASSERT_IMPL(a_fill_bound, 1'b1, fill_count <= CNT_W'(STACK_DEPTH), "fill count overflow")
  `BSBC_ASSERT_IMPL(a_depth_bound, state == B_SCAN_RD, scan_depth <= scan_idx, "opener depth ran ahead of scan")
  `BSBC_ASSERT_NEXT(a_top_result, state == B_TOP_WAIT, res_valid && res.kind == KIND_TOP, "top read gave no result")
  `BSBC_ASSERT_NEXT(a_cached_hit, state == B_IDLE && take && q_cmd.op == OP_QUERY && !stale, res_valid && res.kind == KIND_BAL && res.balanced == $past(cached), "cached answer not returned")

endmodule
